[rtl/core/assert_macros.svh]
// Assertion helpers for the checker file.
// Every property is sampled on the rising edge of clk and is off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a sampled edge.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/core/utf8td_pkg.sv]
// ----------------------------------------------------------------------------
// utf8td_pkg
// Shared types and byte constants for the UTF-8 text detector.
// ----------------------------------------------------------------------------
package utf8td_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  localparam logic [7:0] BOM16_B0   = 8'hFF;
  localparam logic [7:0] BOM16_B1   = 8'hFE;
  localparam logic [7:0] BOM8_B0    = 8'hEF;
  localparam logic [7:0] BOM8_B1    = 8'hBB;
  localparam logic [7:0] BOM8_B2    = 8'hBF;
  localparam logic [7:0] BAD_C0     = 8'hC0;
  localparam logic [7:0] BAD_C1     = 8'hC1;
  localparam logic [7:0] BAD_MIN    = 8'hF5;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_VAL  = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_VAL   = 8'h80;

  localparam logic [2:0] COUNT_MAX  = 3'd4;

endpackage

[rtl/core/utf8td_in_stage.sv]
// ----------------------------------------------------------------------------
// utf8td_in_stage
// Input register: holds one byte transfer until the scan logic takes it.
// ----------------------------------------------------------------------------
module utf8td_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               last,
  input  logic               take,
  output logic               vld,
  output utf8td_pkg::item_t  item
);
  import utf8td_pkg::*;

  logic load;

  assign in_stall = vld && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= 1'b1;
    end else if (take) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.data_byte <= data_byte;
      item.last      <= last;
    end
  end

endmodule

[rtl/core/utf8td_core.sv]
// ----------------------------------------------------------------------------
// utf8td_core
// Per-buffer scan state and the verdict logic for the final byte.
// ----------------------------------------------------------------------------
module utf8td_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  utf8td_pkg::item_t  item,
  output logic               verdict
);
  import utf8td_pkg::*;

  logic [2:0] byte_count, byte_count_next;
  logic       index_parity;
  logic [7:0] recent_bytes [3];
  logic [7:0] leading_bytes [3];
  logic [7:0] leading_bytes_next [3];
  logic       zero_word_found, zero_word_found_next;
  logic       illegal_found, illegal_found_next;
  logic       sequence_error, sequence_error_next;
  logic       multibyte_seen, multibyte_seen_next;
  logic [1:0] skip_count, skip_count_next;

  logic [7:0] b;
  logic       is2, is3, is4, seq_ok;
  logic       cont1, cont0, contb;

  assign b     = item.data_byte;
  assign cont1 = (recent_bytes[1] & CONT_MASK) == CONT_VAL;
  assign cont0 = (recent_bytes[0] & CONT_MASK) == CONT_VAL;
  assign contb = (b & CONT_MASK) == CONT_VAL;
  assign is2   = (recent_bytes[2] & LEAD2_MASK) == LEAD2_VAL;
  assign is3   = (recent_bytes[2] & LEAD3_MASK) == LEAD3_VAL;
  assign is4   = (recent_bytes[2] & LEAD4_MASK) == LEAD4_VAL;
  assign seq_ok = cont1 && (!(is3 || is4) || cont0) && (!is4 || contb);

  always_comb begin
    zero_word_found_next = zero_word_found ||
                           (!index_parity && (byte_count >= 3'd2) &&
                            (recent_bytes[0] == 8'h00) && (recent_bytes[1] == 8'h00));
    illegal_found_next   = illegal_found ||
                           (b == BAD_C0) || (b == BAD_C1) || (b >= BAD_MIN);
    leading_bytes_next   = leading_bytes;
    sequence_error_next  = sequence_error;
    multibyte_seen_next  = multibyte_seen;
    skip_count_next      = skip_count;

    if (byte_count < 3'd3) begin
      leading_bytes_next[byte_count[1:0]] = b;
    end else if (skip_count != 2'd0) begin
      skip_count_next = skip_count - 2'd1;
    end else if (is2 || is3 || is4) begin
      // window lead is a multibyte lead: judge its continuation bytes
      if (seq_ok) begin
        multibyte_seen_next = 1'b1;
      end else begin
        sequence_error_next = 1'b1;
      end
      skip_count_next = is2 ? 2'd1 : (is3 ? 2'd2 : 2'd3);
    end

    byte_count_next = (byte_count == COUNT_MAX) ? COUNT_MAX : byte_count + 3'd1;
  end

  always_comb begin
    if (byte_count == 3'd0) begin
      verdict = 1'b1;
    end else if (zero_word_found_next) begin
      verdict = 1'b0;
    end else if (leading_bytes_next[0] == BOM16_B0 && leading_bytes_next[1] == BOM16_B1) begin
      verdict = 1'b0;
    end else if (byte_count == 3'd1) begin
      verdict = 1'b0;
    end else if (leading_bytes_next[0] == BOM8_B0 && leading_bytes_next[1] == BOM8_B1 &&
                 leading_bytes_next[2] == BOM8_B2) begin
      verdict = 1'b1;
    end else if (illegal_found_next || sequence_error_next) begin
      verdict = 1'b0;
    end else begin
      verdict = multibyte_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && item.last)) begin
      byte_count      <= 3'd0;
      index_parity    <= 1'b0;
      recent_bytes    <= '{default: 8'h00};
      leading_bytes   <= '{default: 8'h00};
      zero_word_found <= 1'b0;
      illegal_found   <= 1'b0;
      sequence_error  <= 1'b0;
      multibyte_seen  <= 1'b0;
      skip_count      <= 2'd0;
    end else if (take) begin
      byte_count      <= byte_count_next;
      index_parity    <= !index_parity;
      recent_bytes[2] <= recent_bytes[1];
      recent_bytes[1] <= recent_bytes[0];
      recent_bytes[0] <= b;
      leading_bytes   <= leading_bytes_next;
      zero_word_found <= zero_word_found_next;
      illegal_found   <= illegal_found_next;
      sequence_error  <= sequence_error_next;
      multibyte_seen  <= multibyte_seen_next;
      skip_count      <= skip_count_next;
    end
  end

endmodule

[rtl/core/utf8td_out_stage.sv]
// ----------------------------------------------------------------------------
// utf8td_out_stage
// Result register: holds a verdict until the output transfer completes.
// ----------------------------------------------------------------------------
module utf8td_out_stage (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  logic verdict,
  output logic room,
  output logic out_valid,
  input  logic out_stall,
  output logic is_utf8
);

  assign room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      is_utf8 <= verdict;
    end
  end

endmodule

[rtl/core/utf8_text_detector.sv]
// The detector takes a buffer one byte per cycle unless in_stall holds it, the final byte
// flagged by last, and gives a single is_utf8 verdict for the whole buffer once the final
// byte has passed the input register and then the result register. Bytes flow back to
// back at one per cycle unless stalled; input stalls only while out_stall holds a finished
// verdict in the result register and the byte in the input register is also a final byte.
// All scan state clears after each verdict, so the next buffer may follow immediately.
// ----------------------------------------------------------------------------
// utf8_text_detector
// Streaming UTF-8 text detector: input register, scan core, result register.
// ----------------------------------------------------------------------------
module utf8_text_detector (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_utf8
);
  import utf8td_pkg::*;

  logic  vld, take, room, verdict;
  item_t item;

  assign take = vld && (!item.last || room);

  utf8td_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last      (last),
    .take      (take),
    .vld       (vld),
    .item      (item)
  );

  utf8td_core u_core (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .item    (item),
    .verdict (verdict)
  );

  utf8td_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && item.last),
    .verdict   (verdict),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_utf8   (is_utf8)
  );

endmodule

[rtl/core/utf8td_checker.sv]
// ----------------------------------------------------------------------------
// utf8td_checker
// Port-level checks on the detector, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8td_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       last,
  input logic       out_valid,
  input logic       out_stall,
  input logic       is_utf8
);

  // final bytes taken in whose verdict has not yet transferred out
  logic [1:0] pending;
  logic       in_last_xfer, out_xfer;

  assign in_last_xfer = in_valid && !in_stall && last;
  assign out_xfer     = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else if (in_last_xfer && !out_xfer) begin
      pending <= pending + 2'd1;
    end else if (out_xfer && !in_last_xfer) begin
      pending <= pending - 2'd1;
    end
  end

  `ASSERT_CLK(a_no_stall_when_empty, !out_valid |-> !in_stall, "input stalled, output empty")
  `ASSERT_CLK(a_hold, out_valid && out_stall |=> out_valid && $stable(is_utf8), "verdict not held")
  `ASSERT_NEVER(a_no_orphan_verdict, out_valid && pending == 2'd0, "verdict without a final byte")
  `ASSERT_NEVER(a_inflight_bound, pending == 2'd3, "more than two buffers in flight")

endmodule

bind utf8_text_detector utf8td_checker u_utf8td_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .last      (last),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .is_utf8   (is_utf8)
);

[tb/sv/tb_utf8_text_detector.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_text_detector
// Sends byte buffers through the detector under random sender gaps and
// receiver stalls, predicts each is_utf8 verdict and checks it in order.
// ----------------------------------------------------------------------------
import utf8td_pkg::*;

class utf8_scoreboard;
  logic [2:0] byte_cnt;
  bit         parity;
  logic [7:0] recent [3];
  logic [7:0] leading [3];
  bit         zero_word;
  bit         illegal;
  bit         seq_err;
  bit         multibyte;
  logic [1:0] skip;
  bit         verdicts_due [$];
  int         errors;

  function new();
    errors = 0;
    clear();
  endfunction

  function void clear();
    byte_cnt  = '0;
    parity    = 1'b0;
    recent    = '{8'h00, 8'h00, 8'h00};
    leading   = '{8'h00, 8'h00, 8'h00};
    zero_word = 1'b0;
    illegal   = 1'b0;
    seq_err   = 1'b0;
    multibyte = 1'b0;
    skip      = '0;
  endfunction

  // Lead sits three bytes behind the input; newest is the byte just taken.
  function void scan_lead(logic [7:0] newest);
    logic [7:0] lead;
    int         len;
    bit         ok;
    lead = recent[2];
    len  = 1;
    ok   = 1'b1;
    if (skip != 0) begin
      skip = skip - 1'b1;
      return;
    end
    if ((lead & LEAD2_MASK) == LEAD2_VAL) len = 2;
    else if ((lead & LEAD3_MASK) == LEAD3_VAL) len = 3;
    else if ((lead & LEAD4_MASK) == LEAD4_VAL) len = 4;
    if (len == 1) return;
    if ((recent[1] & CONT_MASK) != CONT_VAL) ok = 1'b0;
    if (len >= 3 && (recent[0] & CONT_MASK) != CONT_VAL) ok = 1'b0;
    if (len >= 4 && (newest & CONT_MASK) != CONT_VAL) ok = 1'b0;
    if (ok) multibyte = 1'b1;
    else seq_err = 1'b1;
    skip = 2'(len - 1);
  endfunction

  function bit judge(int n);
    if (n < 2) return 1'b1;
    if (zero_word) return 1'b0;
    if (leading[0] == BOM16_B0 && leading[1] == BOM16_B1) return 1'b0;
    if (n < 3) return 1'b0;
    if (leading[0] == BOM8_B0 && leading[1] == BOM8_B1 && leading[2] == BOM8_B2)
      return 1'b1;
    if (illegal) return 1'b0;
    if (seq_err) return 1'b0;
    return multibyte;
  endfunction

  function void note_byte(logic [7:0] b, logic lst);
    int n;
    if (!parity && byte_cnt >= 2 && recent[0] == 8'h00 && recent[1] == 8'h00)
      zero_word = 1'b1;
    if (b == BAD_C0 || b == BAD_C1 || b >= BAD_MIN) illegal = 1'b1;
    if (byte_cnt < 3) leading[byte_cnt] = b;
    else scan_lead(b);
    recent[2] = recent[1];
    recent[1] = recent[0];
    recent[0] = b;
    n = byte_cnt + 1;
    byte_cnt = (n > COUNT_MAX) ? COUNT_MAX : 3'(n);
    parity = ~parity;
    if (lst) begin
      verdicts_due.push_back(judge(n));
      clear();
    end
  endfunction

  function void check_verdict(logic actual);
    bit want;
    if (verdicts_due.size() == 0) begin
      $error("is_utf8: unexpected verdict, actual %0b", actual);
      errors++;
      return;
    end
    want = verdicts_due.pop_front();
    if (actual !== want) begin
      $error("is_utf8 mismatch: expected %0b, actual %0b", want, actual);
      errors++;
    end
  endfunction
endclass

module tb_utf8_text_detector;
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       is_utf8;

  utf8_scoreboard sb = new();

  logic [7:0] text_q [$];
  int         bytes_sent = 0;
  int         burst_left = 0;
  int         stall_mode = 0;
  int         stall_run = 0;
  int         stall_tick = 0;

  utf8_text_detector uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_utf8   (is_utf8)
  );

  always #5 clk = ~clk;

  // Receiver: stall pattern changes after each run of random length.
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = $urandom_range(20, 200);
    end
    stall_run--;
    stall_tick++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_tick % 7) < 3);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_verdict(is_utf8);
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    data_byte <= b;
    last      <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b, lst);
    @(negedge clk);
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    bytes_sent += text_q.size();
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // One well-formed character: ASCII or a valid 2, 3 or 4 byte sequence.
  function automatic void add_char();
    int kind;
    kind = $urandom_range(0, 4);
    case (kind)
      0, 1: text_q.push_back(8'($urandom_range(8'h01, 8'h7F)));
      2: begin
        text_q.push_back(8'($urandom_range(8'hC2, 8'hDF)));
        text_q.push_back(cont_byte());
      end
      3: begin
        text_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        text_q.push_back(cont_byte());
        text_q.push_back(cont_byte());
      end
      default: begin
        text_q.push_back(8'($urandom_range(8'hF0, 8'hF4)));
        text_q.push_back(cont_byte());
        text_q.push_back(cont_byte());
        text_q.push_back(cont_byte());
      end
    endcase
  endfunction

  function automatic void add_chars(int lo, int hi);
    int k;
    int cnt;
    cnt = $urandom_range(lo, hi);
    for (k = 0; k < cnt; k++) add_char();
  endfunction

  function automatic logic [7:0] special_byte();
    case ($urandom_range(0, 8))
      0: return 8'h00;
      1: return BOM16_B0;
      2: return BOM16_B1;
      3: return BOM8_B0;
      4: return BOM8_B1;
      5: return BOM8_B2;
      6: return BAD_C0;
      7: return 8'h41;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : watchdog
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int k;
    int idx;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: one-byte buffer, UTF-16 mark, two-byte buffer, UTF-8 mark,
    // zero word, valid 2 and 4 byte leads, bad continuation, illegal byte, ASCII
    text_q = '{8'h00};                          send_text();
    text_q = '{8'hFF, 8'hFE};                   send_text();
    text_q = '{8'h41, 8'h42};                   send_text();
    text_q = '{8'hEF, 8'hBB, 8'hBF};            send_text();
    text_q = '{8'h00, 8'h00, 8'h41};            send_text();
    text_q = '{8'hC2, 8'hA9, 8'h41, 8'h41};     send_text();
    text_q = '{8'hF0, 8'h9F, 8'h98, 8'h80};     send_text();
    text_q = '{8'hE2, 8'h28, 8'hA1, 8'h41};     send_text();
    text_q = '{8'h41, 8'hF5, 8'h41};            send_text();
    text_q = '{8'h41, 8'h42, 8'h43, 8'h44};     send_text();

    while (bytes_sent < 730) begin
      text_q.delete();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: add_chars(1, 12);
        5: begin
          for (k = $urandom_range(1, 10); k > 0; k--)
            text_q.push_back(8'($urandom_range(0, 255)));
        end
        6: begin
          add_chars(2, 10);
          if ($urandom_range(0, 1) && text_q.size() > 1) begin
            void'(text_q.pop_back());
          end else begin
            idx = $urandom_range(0, text_q.size() - 1);
            text_q[idx] = 8'($urandom_range(0, 255));
          end
        end
        7: begin
          if ($urandom_range(0, 1)) begin
            text_q.push_back(BOM8_B0);
            text_q.push_back(BOM8_B1);
            text_q.push_back(BOM8_B2);
          end else begin
            text_q.push_back(BOM16_B0);
            text_q.push_back(BOM16_B1);
          end
          add_chars(0, 6);
        end
        8: begin
          // zero word at either byte parity
          for (k = $urandom_range(0, 3); k > 0; k--)
            text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
          text_q.push_back(8'h00);
          text_q.push_back(8'h00);
          for (k = $urandom_range(0, 4); k > 0; k--)
            text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
        default: begin
          for (k = $urandom_range(1, 3); k > 0; k--) text_q.push_back(special_byte());
        end
      endcase
      send_text();
    end
    in_valid <= 1'b0;
    last     <= 1'b0;

    while (sb.verdicts_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.verdicts_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
